FILE: rtl/led_pulse_animator_core_defines.svh
// ----------------------------------------------------------------------------
// led_pulse_animator_core_defines
// Assertion macros shared by the LED pulse animator RTL.
// ----------------------------------------------------------------------------
`ifndef LED_PULSE_ANIMATOR_CORE_DEFINES_SVH
`define LED_PULSE_ANIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define LPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define LPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lpa_pkg.sv
// ----------------------------------------------------------------------------
// lpa_pkg
// Types and constants shared by the LED pulse animator modules.
// ----------------------------------------------------------------------------
package lpa_pkg;

    // Divider sizing: largest numerator is 254 times a 15-bit interval.
    localparam int DIV_NUM_W = 23;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BLINK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOL  = 2'd2;

    localparam logic [15:0] BLINK_RESET = 16'd2000;
    localparam logic [9:0]  FRAME_RESET = 10'd50;
    localparam logic [14:0] COOL_RESET  = 15'd1000;

    // Event codes.
    localparam logic [1:0] EVT_FIRE = 2'd1;
    localparam logic [1:0] EVT_HIT  = 2'd2;

    // Brightness scale factors.
    localparam int IDLE_SCALE = 40;
    localparam int HIT_SCALE  = 254;
    localparam int FIRE_SCALE = 128;
    localparam logic [7:0] LED_MAX = 8'd255;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_FIRE = 2'd1,
        MODE_HIT  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DECIDE,
        ST_DIV,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [31:0]        now_ms;
        logic               health_is_zero;
        logic signed [15:0] cooldown_left;
    } in_item_t;

    typedef struct packed {
        logic       frame_shown;
        logic [7:0] led0_red;
        logic [7:0] led0_green;
        logic [7:0] led1_green;
        logic [1:0] anim_mode;
    } out_item_t;

    typedef struct packed {
        logic [15:0] blink_interval_ms;
        logic [9:0]  frame_period_ms;
        logic [14:0] cooldown_full;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic decide;
        logic finish;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } dp_sts_t;

endpackage

FILE: rtl/lpa_div.sv
// ----------------------------------------------------------------------------
// lpa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lpa_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [lpa_pkg::DIV_NUM_W-1:0]       num,
    input  logic [lpa_pkg::DIV_DEN_W-1:0]       den,
    output logic                                done,
    output logic [lpa_pkg::DIV_NUM_W-1:0]       quo
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [lpa_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [lpa_pkg::DIV_DEN_W:0]       rem_reg, rem_next;
    logic [lpa_pkg::DIV_NUM_W-1:0]     quo_reg, quo_next;
    logic [lpa_pkg::DIV_DEN_W-1:0]     den_reg, den_next;
    logic [lpa_pkg::DIV_DEN_W:0]       shifted;
    logic                              ge;

    // The quotient register doubles as the numerator shift register.
    always_comb begin
        shifted   = {rem_reg[lpa_pkg::DIV_DEN_W-1:0], quo_reg[lpa_pkg::DIV_NUM_W-1]};
        ge        = shifted >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = lpa_pkg::DIV_CNT_W'(lpa_pkg::DIV_NUM_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            rem_next = ge ? (shifted - {1'b0, den_reg}) : shifted;
            quo_next = {quo_reg[lpa_pkg::DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg - lpa_pkg::DIV_CNT_W'(1);
            if (cnt_reg == lpa_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

FILE: rtl/lpa_dp.sv
// ----------------------------------------------------------------------------
// lpa_dp
// Animation state, timing arithmetic, frame decisions and result register.
// ----------------------------------------------------------------------------
module lpa_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lpa_pkg::ctrl_cmd_t    cmd,
    output lpa_pkg::dp_sts_t      sts,
    input  lpa_pkg::cfg_t         cfg,
    input  lpa_pkg::in_item_t     s_data,
    output lpa_pkg::out_item_t    m_data
);

    lpa_pkg::mode_t      mode_reg, mode_next;
    logic [31:0]         start_reg, start_next;
    logic [31:0]         last_reg, last_next;
    logic [7:0]          red_reg, red_next;
    logic [7:0]          green_reg, green_next;
    logic [7:0]          g1_reg, g1_next;

    lpa_pkg::in_item_t   item_reg;
    logic [31:0]         r_reg, sq_reg;
    logic                render_reg;
    logic                shown_reg, shown_next;
    logic                add1_reg, add1_next;
    lpa_pkg::out_item_t  out_reg;

    logic [14:0]         half_iv;
    logic [15:0]         opnd;
    logic [16:0]         offset;
    logic [16:0]         two_b;
    logic [16:0]         idle_back;
    logic [14:0]         hit_back;
    logic [31:0]         elapsed;
    logic [31:0]         r_calc;
    logic [31:0]         sq_calc;
    logic                need_div;
    logic [lpa_pkg::DIV_NUM_W-1:0] div_num;
    logic [lpa_pkg::DIV_DEN_W-1:0] div_den;
    logic                div_done;
    logic [lpa_pkg::DIV_NUM_W-1:0] quo;
    logic [7:0]          val8;

    // Remaining time of the current animation and its expiry bound.
    always_comb begin
        half_iv = cfg.blink_interval_ms[15:1];
        two_b   = {cfg.blink_interval_ms, 1'b0};
        opnd    = (mode_reg == lpa_pkg::MODE_HIT) ? {1'b0, half_iv} : cfg.blink_interval_ms;
        offset  = (mode_reg == lpa_pkg::MODE_HIT) ? {2'b00, half_iv} : two_b;
        elapsed = item_reg.now_ms - last_reg;
        r_calc  = start_reg + {15'b0, offset} - item_reg.now_ms;
        sq_calc = 32'(opnd) * 32'(opnd);
        idle_back = two_b - r_reg[16:0];
        hit_back  = half_iv - r_reg[14:0];
    end

    always_comb begin
        if (mode_reg == lpa_pkg::MODE_FIRE) begin
            val8 = (quo > lpa_pkg::DIV_NUM_W'(lpa_pkg::LED_MAX)) ? lpa_pkg::LED_MAX : quo[7:0];
        end else begin
            val8 = quo[7:0] + {7'b0, add1_reg};
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        start_next = start_reg;
        last_next  = last_reg;
        red_next   = red_reg;
        green_next = green_reg;
        g1_next    = g1_reg;
        shown_next = shown_reg;
        add1_next  = add1_reg;
        need_div   = 1'b0;
        div_num    = '0;
        div_den    = cfg.blink_interval_ms;

        if (cmd.load) begin
            if (s_data.cmd == lpa_pkg::EVT_FIRE) begin
                start_next = s_data.now_ms;
                mode_next  = lpa_pkg::MODE_FIRE;
            end else if (s_data.cmd == lpa_pkg::EVT_HIT) begin
                start_next = s_data.now_ms;
                mode_next  = lpa_pkg::MODE_HIT;
            end
        end

        if (cmd.eval && (elapsed > {22'b0, cfg.frame_period_ms})) begin
            last_next = item_reg.now_ms;
        end

        if (cmd.decide) begin
            shown_next = 1'b0;
            add1_next  = 1'b0;
            if (render_reg) begin
                case (mode_reg)
                    lpa_pkg::MODE_FIRE: begin
                        if (item_reg.cooldown_left[15] || (item_reg.cooldown_left == '0)) begin
                            g1_next   = '0;
                            mode_next = lpa_pkg::MODE_IDLE;
                        end else begin
                            shown_next = 1'b1;
                            need_div   = 1'b1;
                            div_num    = lpa_pkg::DIV_NUM_W'(item_reg.cooldown_left[14:0])
                                         * lpa_pkg::DIV_NUM_W'(lpa_pkg::FIRE_SCALE);
                            div_den    = (cfg.cooldown_full == '0) ? 16'd1
                                                                   : {1'b0, cfg.cooldown_full};
                        end
                    end
                    lpa_pkg::MODE_IDLE: begin
                        if ((cfg.blink_interval_ms == '0) || (r_reg > sq_reg)) begin
                            start_next = item_reg.now_ms;
                        end else begin
                            shown_next = 1'b1;
                            if (r_reg < {16'b0, cfg.blink_interval_ms}) begin
                                need_div  = 1'b1;
                                add1_next = 1'b1;
                                div_num   = lpa_pkg::DIV_NUM_W'(r_reg[15:0])
                                            * lpa_pkg::DIV_NUM_W'(lpa_pkg::IDLE_SCALE);
                            end else if (r_reg <= {15'b0, two_b}) begin
                                need_div  = 1'b1;
                                add1_next = 1'b1;
                                div_num   = lpa_pkg::DIV_NUM_W'(idle_back[15:0])
                                            * lpa_pkg::DIV_NUM_W'(lpa_pkg::IDLE_SCALE);
                            end else begin
                                red_next   = '0;
                                green_next = '0;
                            end
                        end
                    end
                    lpa_pkg::MODE_HIT: begin
                        if ((half_iv == '0) || ({r_reg, 1'b0} > {1'b0, sq_reg})) begin
                            start_next = item_reg.now_ms;
                            red_next   = '0;
                            green_next = '0;
                            mode_next  = lpa_pkg::MODE_IDLE;
                        end else begin
                            shown_next = 1'b1;
                            green_next = '0;
                            div_den    = {1'b0, half_iv};
                            if ({r_reg, 1'b0} < {18'b0, half_iv}) begin
                                need_div  = 1'b1;
                                add1_next = 1'b1;
                                div_num   = lpa_pkg::DIV_NUM_W'(r_reg[14:0])
                                            * lpa_pkg::DIV_NUM_W'(lpa_pkg::HIT_SCALE);
                            end else if (r_reg < {17'b0, half_iv}) begin
                                need_div = 1'b1;
                                div_num  = lpa_pkg::DIV_NUM_W'(hit_back)
                                           * lpa_pkg::DIV_NUM_W'(lpa_pkg::HIT_SCALE);
                            end else begin
                                red_next = '0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (cmd.finish) begin
            case (mode_reg)
                lpa_pkg::MODE_FIRE: begin
                    g1_next = val8;
                end
                lpa_pkg::MODE_IDLE: begin
                    red_next   = item_reg.health_is_zero ? val8 : 8'd0;
                    green_next = item_reg.health_is_zero ? 8'd0 : val8;
                end
                lpa_pkg::MODE_HIT: begin
                    red_next = val8;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= lpa_pkg::MODE_IDLE;
            start_reg <= '0;
            last_reg  <= '0;
            red_reg   <= '0;
            green_reg <= '0;
            g1_reg    <= '0;
        end else begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            last_reg  <= last_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            g1_reg    <= g1_next;
        end
    end

    always_ff @(posedge aclk) begin
        shown_reg <= shown_next;
        add1_reg  <= add1_next;
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.eval) begin
            render_reg <= elapsed > {22'b0, cfg.frame_period_ms};
            r_reg      <= r_calc;
            sq_reg     <= sq_calc;
        end
        if (cmd.emit) begin
            out_reg.frame_shown <= shown_reg;
            out_reg.led0_red    <= red_reg;
            out_reg.led0_green  <= green_reg;
            out_reg.led1_green  <= g1_reg;
            out_reg.anim_mode   <= mode_reg;
        end
    end

    lpa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.decide && need_div),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (quo)
    );

    assign sts.need_div = need_div;
    assign sts.div_done = div_done;
    assign m_data       = out_reg;

endmodule

FILE: rtl/lpa_ctrl.sv
// ----------------------------------------------------------------------------
// lpa_ctrl
// Sequencer for one request: evaluate, decide, divide if needed, hand off.
// ----------------------------------------------------------------------------
module lpa_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  lpa_pkg::dp_sts_t      sts,
    output lpa_pkg::ctrl_cmd_t    cmd
);

    lpa_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lpa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = lpa_pkg::ST_EVAL;
                end
            end
            lpa_pkg::ST_EVAL: begin
                state_next = lpa_pkg::ST_DECIDE;
            end
            lpa_pkg::ST_DECIDE: begin
                state_next = sts.need_div ? lpa_pkg::ST_DIV : lpa_pkg::ST_WRITE;
            end
            lpa_pkg::ST_DIV: begin
                if (sts.div_done) begin
                    state_next = lpa_pkg::ST_WRITE;
                end
            end
            lpa_pkg::ST_WRITE: begin
                if (slot_free) begin
                    state_next = lpa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = (state_reg == lpa_pkg::ST_IDLE);
        cmd.load   = (state_reg == lpa_pkg::ST_IDLE) && s_valid;
        cmd.eval   = (state_reg == lpa_pkg::ST_EVAL);
        cmd.decide = (state_reg == lpa_pkg::ST_DECIDE);
        cmd.finish = (state_reg == lpa_pkg::ST_DIV) && sts.div_done;
        cmd.emit   = (state_reg == lpa_pkg::ST_WRITE) && slot_free;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lpa_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/led_pulse_animator_core.sv
// ----------------------------------------------------------------------------
// led_pulse_animator_core
// Game-event LED animator: idle breathing, hit flash and fire cooldown glow.
// ----------------------------------------------------------------------------
// Each request on the s_ channel carries an event code, a millisecond
// timestamp, the zero-health flag and the remaining weapon cooldown. Every
// request yields exactly one result on the m_ channel: the LED channel
// values after the request, the animation mode and whether a frame was shown.
// m_valid rises once the request has passed the EVAL, DECIDE and WRITE
// states when no brightness is computed, with the DIV state between DECIDE
// and WRITE when one is; there the 23-bit restoring divider yields one
// quotient bit per cycle. One request is in work at a time and s_ready
// returns in the cycle the result is loaded. The result sits in an output
// register: a new request is taken while it waits, and the block only holds
// in its final step if the receiver has not yet taken the previous result.
// Configuration writes through cfg_we, cfg_idx and cfg_wdata take effect at
// once; the user must make them only while idle, which the block does not
// enforce. Reset restores the default intervals, idle mode, all LEDs dark
// and the animation and frame times at zero.
// ----------------------------------------------------------------------------
`include "led_pulse_animator_core_defines.svh"

module led_pulse_animator_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lpa_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lpa_pkg::out_item_t                 m_data,
    input  logic                               cfg_we,
    input  logic [lpa_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [lpa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    lpa_pkg::cfg_t       cfg_reg, cfg_next;
    lpa_pkg::ctrl_cmd_t  cmd;
    lpa_pkg::dp_sts_t    sts;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx)
                lpa_pkg::CFG_BLINK: cfg_next.blink_interval_ms = cfg_wdata;
                lpa_pkg::CFG_FRAME: cfg_next.frame_period_ms   = cfg_wdata[9:0];
                lpa_pkg::CFG_COOL:  cfg_next.cooldown_full     = cfg_wdata[14:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blink_interval_ms <= lpa_pkg::BLINK_RESET;
            cfg_reg.frame_period_ms   <= lpa_pkg::FRAME_RESET;
            cfg_reg.cooldown_full     <= lpa_pkg::COOL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    lpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lpa_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .cfg     (cfg_reg),
        .s_data  (s_data),
        .m_data  (m_data)
    );

    // Only one request is in work: acceptance always drops s_ready.
    `LPA_ASSERT_NEXT(a_one_in_work, s_valid && s_ready, !s_ready, "request accepted while busy")

    // A shown hit frame drives red only, and never beyond its peak.
    `LPA_ASSERT_NOW(a_hit_red_only, m_valid && m_data.frame_shown && (m_data.anim_mode == lpa_pkg::MODE_HIT), (m_data.led0_green == 8'd0) && (m_data.led0_red <= 8'd127), "hit frame out of range")

    // In idle the first LED is lit in one color at most.
    `LPA_ASSERT_NOW(a_idle_one_color, m_valid && (m_data.anim_mode == lpa_pkg::MODE_IDLE), (m_data.led0_red == 8'd0) || (m_data.led0_green == 8'd0), "idle LED lit in two colors")

endmodule
